/* hdl/ffpx_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffpx_pkg
// Shared types and constants of the fixed-length frame parser.
// ----------------------------------------------------------------------------
package ffpx_pkg;

    localparam int BYTE_W      = 8;
    localparam int POS_W       = 5;
    localparam int STORE_DEPTH = 14;
    localparam int STATUS_W    = 3;
    localparam int CFG_IDX_W   = 2;
    localparam int GOOD_W      = 32;
    localparam int OUT_FIELD_W = 131;
    localparam int OUT_DATA_W  = 136;

    localparam logic [POS_W-1:0] POS_HDR1       = 5'd0;
    localparam logic [POS_W-1:0] POS_HDR2       = 5'd1;
    localparam logic [POS_W-1:0] POS_FIRST_DATA = 5'd2;
    localparam logic [POS_W-1:0] POS_LAST_XOR   = 5'd14;
    localparam logic [POS_W-1:0] POS_FOOTER     = 5'd16;

    localparam logic [CFG_IDX_W-1:0] REG_HEADER_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_SECOND = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FOOTER_VALUE  = 2'd2;

    localparam logic [BYTE_W-1:0] HEADER_FIRST_RST  = 8'hAA;
    localparam logic [BYTE_W-1:0] HEADER_SECOND_RST = 8'h55;
    localparam logic [BYTE_W-1:0] FOOTER_VALUE_RST  = 8'h5B;

    typedef enum logic [STATUS_W-1:0] {
        ST_BUSY       = 3'd0,
        ST_SYNC_DROP  = 3'd1,
        ST_OK         = 3'd2,
        ST_BAD_FOOTER = 3'd3,
        ST_BAD_CHECK  = 3'd4
    } status_t;

endpackage

/* hdl/ffpx_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffpx_cell
// One byte cell of the frame store; takes its neighbor's byte on a shift.
// ----------------------------------------------------------------------------
module ffpx_cell (
    input  logic                         aclk,
    input  logic                         shift_en,
    input  logic [ffpx_pkg::BYTE_W-1:0]  din,
    output logic [ffpx_pkg::BYTE_W-1:0]  dout
);

    logic [ffpx_pkg::BYTE_W-1:0] byte_reg;

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            byte_reg <= din;
        end
    end

    assign dout = byte_reg;

endmodule

/* hdl/fixed_frame_parser_xor_check.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_frame_parser_xor_check
// Hunts for a two-byte header, collects a 17-byte frame in a chain of byte
// cells, checks footer and XOR checksum, and decodes good frames.
// ----------------------------------------------------------------------------
// Output: one registered result per request, valid in the cycle after the request is accepted.
// Throughput: one byte per cycle; the output register is reloaded in the same
// cycle it is taken, so the block stalls only while the result is not taken.
// Reset: synchronous active-low aresetn clears position, checksum, counter,
// output valid and loads the default header and footer bytes.
module fixed_frame_parser_xor_check #(
    parameter int COUNTER_WIDTH = 32
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // [7:0] data_byte
    input  logic [ffpx_pkg::BYTE_W-1:0]          s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [7:0] frame_type, [23:8] sequence_res, [24] camera_ok,
    // [25] target_detected, [26] uart_rx_seen, [42:27] center_x,
    // [58:43] center_y, [74:59] pixel_count, [90:75] fps_tenths,
    // [98:91] mean_lightness, [130:99] good_frames, [135:131] zero
    output logic [ffpx_pkg::OUT_DATA_W-1:0]      m_tdata,
    // [2:0] status
    output logic [ffpx_pkg::STATUS_W-1:0]        m_tuser,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [ffpx_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ffpx_pkg::BYTE_W-1:0]          cfg_data
);

    logic [ffpx_pkg::BYTE_W-1:0]    hdr1_reg, hdr2_reg, ftr_reg;
    logic [ffpx_pkg::POS_W-1:0]     pos_reg, pos_next;
    logic [ffpx_pkg::BYTE_W-1:0]    xor_reg, xor_next;
    logic [COUNTER_WIDTH-1:0]       cnt_reg, cnt_next;
    logic                           m_valid_reg, m_valid_next;
    logic [ffpx_pkg::OUT_DATA_W-1:0] m_data_reg, m_data_next;
    ffpx_pkg::status_t              m_status_reg, status_next;
    logic                           in_accept;
    logic                           shift_en;
    logic [ffpx_pkg::BYTE_W-1:0]    cell_q [ffpx_pkg::STORE_DEPTH];
    logic [ffpx_pkg::GOOD_W-1:0]    good_low;
    logic [ffpx_pkg::OUT_FIELD_W-ffpx_pkg::GOOD_W-1:0] fields;

    assign s_tready  = !m_valid_reg || m_tready;
    assign in_accept = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // Cell 0 holds the newest byte; a byte at position p sits in cell 15 - p
    // when the footer arrives.
    genvar k;
    generate
        for (k = 0; k < ffpx_pkg::STORE_DEPTH; k++) begin : g_cell
            if (k == 0) begin : g_head
                ffpx_cell u_cell (
                    .aclk     (aclk),
                    .shift_en (shift_en),
                    .din      (s_tdata),
                    .dout     (cell_q[k])
                );
            end else begin : g_body
                ffpx_cell u_cell (
                    .aclk     (aclk),
                    .shift_en (shift_en),
                    .din      (cell_q[k-1]),
                    .dout     (cell_q[k])
                );
            end
        end
    endgenerate

    always_comb begin
        pos_next    = pos_reg;
        xor_next    = xor_reg;
        cnt_next    = cnt_reg;
        status_next = ffpx_pkg::ST_BUSY;
        shift_en    = 1'b0;
        if (in_accept) begin
            if (pos_reg == ffpx_pkg::POS_HDR1) begin
                if (s_tdata == hdr1_reg) begin
                    pos_next = ffpx_pkg::POS_HDR2;
                end else begin
                    status_next = ffpx_pkg::ST_SYNC_DROP;
                end
            end else if (pos_reg == ffpx_pkg::POS_HDR2) begin
                if (s_tdata == hdr2_reg) begin
                    pos_next = ffpx_pkg::POS_FIRST_DATA;
                    xor_next = '0;
                end else begin
                    status_next = ffpx_pkg::ST_SYNC_DROP;
                    pos_next = (s_tdata == hdr1_reg) ? ffpx_pkg::POS_HDR2
                                                     : ffpx_pkg::POS_HDR1;
                end
            end else if (pos_reg < ffpx_pkg::POS_FOOTER) begin
                shift_en = 1'b1;
                if (pos_reg <= ffpx_pkg::POS_LAST_XOR) begin
                    xor_next = xor_reg ^ s_tdata;
                end
                pos_next = pos_reg + 5'd1;
            end else begin
                pos_next = ffpx_pkg::POS_HDR1;
                if (s_tdata != ftr_reg) begin
                    status_next = ffpx_pkg::ST_BAD_FOOTER;
                end else if (cell_q[0] != xor_reg) begin
                    status_next = ffpx_pkg::ST_BAD_CHECK;
                end else begin
                    status_next = ffpx_pkg::ST_OK;
                    cnt_next    = cnt_reg + {{(COUNTER_WIDTH-1){1'b0}}, 1'b1};
                end
            end
        end
    end

    generate
        if (COUNTER_WIDTH >= ffpx_pkg::GOOD_W) begin : g_cnt_wide
            assign good_low = cnt_next[ffpx_pkg::GOOD_W-1:0];
        end else begin : g_cnt_narrow
            assign good_low = {{(ffpx_pkg::GOOD_W-COUNTER_WIDTH){1'b0}}, cnt_next};
        end
    endgenerate

    always_comb begin
        fields = '0;
        if (status_next == ffpx_pkg::ST_OK) begin
            fields = {cell_q[1],                 // mean_lightness
                      cell_q[2], cell_q[3],      // fps_tenths
                      cell_q[4], cell_q[5],      // pixel_count
                      cell_q[6], cell_q[7],      // center_y
                      cell_q[8], cell_q[9],      // center_x
                      cell_q[10][2:0],           // flag bits
                      cell_q[11], cell_q[12],    // sequence_res
                      cell_q[13]};               // frame_type
        end
        m_data_next = {{(ffpx_pkg::OUT_DATA_W-ffpx_pkg::OUT_FIELD_W){1'b0}}, good_low, fields};
    end

    assign m_valid_next = in_accept || (m_valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hdr1_reg    <= ffpx_pkg::HEADER_FIRST_RST;
            hdr2_reg    <= ffpx_pkg::HEADER_SECOND_RST;
            ftr_reg     <= ffpx_pkg::FOOTER_VALUE_RST;
            pos_reg     <= ffpx_pkg::POS_HDR1;
            xor_reg     <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    ffpx_pkg::REG_HEADER_FIRST:  hdr1_reg <= cfg_data;
                    ffpx_pkg::REG_HEADER_SECOND: hdr2_reg <= cfg_data;
                    ffpx_pkg::REG_FOOTER_VALUE:  ftr_reg  <= cfg_data;
                    default: begin
                    end
                endcase
            end
            pos_reg     <= pos_next;
            xor_reg     <= xor_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            m_data_reg   <= m_data_next;
            m_status_reg <= status_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_status_reg;

endmodule

/* hdl/ffpx_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffpx_checker
// Port-level checks of the frame parser, bound to the top level.
// ----------------------------------------------------------------------------
module ffpx_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tready,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [ffpx_pkg::OUT_DATA_W-1:0]  m_tdata,
    input  logic [ffpx_pkg::STATUS_W-1:0]    m_tuser
);

    a_reset_clears_valid : assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_ready_when_empty : assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output register");

    a_fields_zero : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != ffpx_pkg::ST_OK) |-> (m_tdata[98:0] == '0))
        else $error("decoded fields set on a result that is not a good frame");

    a_hold_stalled : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

endmodule

bind fixed_frame_parser_xor_check ffpx_checker u_ffpx_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

/* tb/tb_fixed_frame_parser_xor_check.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fixed_frame_parser_xor_check
// Streams link bytes into the frame parser and checks the status and the
// decoded fields of every result against a byte-level model of the parser.
// Stimulus is mostly well-formed frames with random content, mixed with
// broken checksums, broken footers, cut frames, bad headers and noise, under
// several header and footer settings and random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_fixed_frame_parser_xor_check;

    localparam logic [ffpx_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int PHASE_BYTES = 100;
    localparam int QUIET_LIMIT = 1000;

    typedef enum int {
        FR_GOOD,
        FR_BAD_CHECK,
        FR_BAD_FOOTER,
        FR_BAD_HEADER,
        FR_CUT,
        FR_NOISE
    } frame_kind_t;

    typedef struct packed {
        ffpx_pkg::status_t  status;
        logic [7:0]         frame_type;
        logic [15:0]        sequence_res;
        logic               camera_ok;
        logic               target_detected;
        logic               uart_rx_seen;
        logic signed [15:0] center_x;
        logic signed [15:0] center_y;
        logic [15:0]        pixel_count;
        logic [15:0]        fps_tenths;
        logic [7:0]         mean_lightness;
        logic [31:0]        good_frames;
    } frame_result_t;

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [ffpx_pkg::BYTE_W-1:0]     s_tdata   = '0;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [ffpx_pkg::OUT_DATA_W-1:0] m_tdata;
    logic [ffpx_pkg::STATUS_W-1:0]   m_tuser;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [ffpx_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [ffpx_pkg::BYTE_W-1:0]     cfg_data  = '0;

    logic [7:0]    byte_queue[$];
    frame_result_t expected_results[$];
    int            bytes_fed  = 0;
    int            errors     = 0;
    int            src_gap    = 0;
    int            sink_gap   = 0;
    int            quiet      = 0;
    bit            calm       = 1'b0;
    logic          s_fire     = 1'b0;

    logic [7:0]                 cfg_header_first  = ffpx_pkg::HEADER_FIRST_RST;
    logic [7:0]                 cfg_header_second = ffpx_pkg::HEADER_SECOND_RST;
    logic [7:0]                 cfg_footer        = ffpx_pkg::FOOTER_VALUE_RST;
    logic [ffpx_pkg::POS_W-1:0] parse_pos         = ffpx_pkg::POS_HDR1;
    logic [7:0]                 frame_bytes [2:15];
    logic [7:0]                 running_sum       = '0;
    logic [31:0]                good_count        = '0;

    fixed_frame_parser_xor_check i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    function automatic frame_result_t parse_byte(logic [7:0] b);
        frame_result_t r;
        r = '0;
        r.status = ffpx_pkg::ST_BUSY;
        if (parse_pos == ffpx_pkg::POS_HDR1) begin
            if (b == cfg_header_first) parse_pos = ffpx_pkg::POS_HDR2;
            else r.status = ffpx_pkg::ST_SYNC_DROP;
        end else if (parse_pos == ffpx_pkg::POS_HDR2) begin
            if (b == cfg_header_second) begin
                parse_pos   = ffpx_pkg::POS_FIRST_DATA;
                running_sum = '0;
            end else begin
                r.status  = ffpx_pkg::ST_SYNC_DROP;
                parse_pos = (b == cfg_header_first) ? ffpx_pkg::POS_HDR2
                                                    : ffpx_pkg::POS_HDR1;
            end
        end else if (parse_pos < ffpx_pkg::POS_FOOTER) begin
            frame_bytes[parse_pos] = b;
            if (parse_pos <= ffpx_pkg::POS_LAST_XOR) running_sum ^= b;
            parse_pos = parse_pos + 5'd1;
        end else begin
            parse_pos = ffpx_pkg::POS_HDR1;
            if (b != cfg_footer) begin
                r.status = ffpx_pkg::ST_BAD_FOOTER;
            end else if (frame_bytes[15] != running_sum) begin
                r.status = ffpx_pkg::ST_BAD_CHECK;
            end else begin
                r.status          = ffpx_pkg::ST_OK;
                good_count        = good_count + 32'd1;
                r.frame_type      = frame_bytes[2];
                r.sequence_res    = {frame_bytes[4], frame_bytes[3]};
                r.camera_ok       = frame_bytes[5][0];
                r.target_detected = frame_bytes[5][1];
                r.uart_rx_seen    = frame_bytes[5][2];
                r.center_x        = {frame_bytes[7], frame_bytes[6]};
                r.center_y        = {frame_bytes[9], frame_bytes[8]};
                r.pixel_count     = {frame_bytes[11], frame_bytes[10]};
                r.fps_tenths      = {frame_bytes[13], frame_bytes[12]};
                r.mean_lightness  = frame_bytes[14];
            end
        end
        r.good_frames = good_count;
        return r;
    endfunction

    function automatic void feed(logic [7:0] b);
        byte_queue.push_back(b);
        bytes_fed++;
    endfunction

    function automatic void queue_frame(frame_kind_t kind, logic [7:0] body [13]);
        logic [7:0] sum;
        int         cut;
        sum = '0;
        foreach (body[i]) sum ^= body[i];
        case (kind)
            FR_NOISE: begin
                repeat ($urandom_range(1, 4)) feed(8'($urandom_range(0, 255)));
            end
            FR_BAD_HEADER: begin
                feed(cfg_header_first);
                feed($urandom_range(0, 1) ? cfg_header_first : 8'($urandom_range(0, 255)));
            end
            FR_CUT: begin
                cut = $urandom_range(0, 12);
                feed(cfg_header_first);
                feed(cfg_header_second);
                for (int i = 0; i < cut; i++) feed(body[i]);
            end
            default: begin
                feed(cfg_header_first);
                feed(cfg_header_second);
                foreach (body[i]) feed(body[i]);
                feed(kind == FR_BAD_CHECK ? sum ^ 8'($urandom_range(1, 255)) : sum);
                feed(kind == FR_BAD_FOOTER ? cfg_footer ^ 8'($urandom_range(1, 255))
                                           : cfg_footer);
            end
        endcase
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endfunction

    task automatic write_reg(logic [ffpx_pkg::CFG_IDX_W-1:0] idx, logic [7:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            ffpx_pkg::REG_HEADER_FIRST:  cfg_header_first  = val;
            ffpx_pkg::REG_HEADER_SECOND: cfg_header_second = val;
            ffpx_pkg::REG_FOOTER_VALUE:  cfg_footer        = val;
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        do @(posedge aclk);
        while (byte_queue.size() != 0 || s_tvalid || expected_results.size() != 0);
        repeat (3) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        s_fire <= aresetn && s_tvalid && s_tready;
    end

    always @(negedge aclk) begin
        logic       next_valid;
        logic [7:0] next_data;
        next_valid = s_tvalid;
        next_data  = s_tdata;
        if (s_fire) begin
            expected_results.push_back(parse_byte(s_tdata));
            next_valid = 1'b0;
        end
        if (aresetn && !next_valid) begin
            if (src_gap > 0) begin
                src_gap--;
            end else if (byte_queue.size() > 0) begin
                if (!calm && $urandom_range(0, 7) == 0) begin
                    src_gap = $urandom_range(1, 10);
                end else begin
                    next_valid = 1'b1;
                    next_data  = byte_queue.pop_front();
                end
            end
        end
        s_tvalid <= next_valid;
        s_tdata  <= next_data;
    end

    always @(negedge aclk) begin
        if (!calm && sink_gap == 0 && $urandom_range(0, 9) == 0) begin
            sink_gap = $urandom_range(1, 10);
        end
        if (sink_gap > 0) begin
            sink_gap--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        frame_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                $error("result 0x%0h with status %0d arrived with no request pending",
                       m_tdata, m_tuser);
                errors++;
            end else begin
                want = expected_results.pop_front();
                check_field("status", 32'(want.status), 32'(m_tuser));
                check_field("frame_type", 32'(want.frame_type), 32'(m_tdata[7:0]));
                check_field("sequence_res", 32'(want.sequence_res), 32'(m_tdata[23:8]));
                check_field("camera_ok", 32'(want.camera_ok), 32'(m_tdata[24]));
                check_field("target_detected", 32'(want.target_detected),
                            32'(m_tdata[25]));
                check_field("uart_rx_seen", 32'(want.uart_rx_seen), 32'(m_tdata[26]));
                check_field("center_x", 32'($unsigned(want.center_x)),
                            32'(m_tdata[42:27]));
                check_field("center_y", 32'($unsigned(want.center_y)),
                            32'(m_tdata[58:43]));
                check_field("pixel_count", 32'(want.pixel_count), 32'(m_tdata[74:59]));
                check_field("fps_tenths", 32'(want.fps_tenths), 32'(m_tdata[90:75]));
                check_field("mean_lightness", 32'(want.mean_lightness),
                            32'(m_tdata[98:91]));
                check_field("good_frames", want.good_frames, m_tdata[130:99]);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("[fixed_frame_parser_xor_check] ERROR");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    initial begin
        logic [7:0]  body [13];
        int          start;
        int          pick;
        frame_kind_t kind;

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Noise, a bad second byte, a resync on a repeated first byte, and one
        // good frame whose fields sit at their extremes.
        feed(8'h00);
        feed(8'hFF);
        feed(cfg_header_first);
        feed(8'h00);
        feed(cfg_header_first);
        body = '{8'hFF, 8'hFF, 8'hFF, 8'h07, 8'h00, 8'h80, 8'hFF, 8'h7F,
                 8'h00, 8'h00, 8'hFF, 8'hFF, 8'h00};
        queue_frame(FR_GOOD, body);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                1: begin
                    write_reg(ffpx_pkg::REG_HEADER_FIRST, 8'h00);
                    write_reg(ffpx_pkg::REG_HEADER_SECOND, 8'hFF);
                    write_reg(ffpx_pkg::REG_FOOTER_VALUE, 8'h00);
                    write_reg(REG_UNUSED, 8'($urandom_range(0, 255)));
                end
                2: begin
                    write_reg(ffpx_pkg::REG_HEADER_FIRST, 8'hFF);
                    write_reg(ffpx_pkg::REG_HEADER_SECOND, 8'h00);
                    write_reg(ffpx_pkg::REG_FOOTER_VALUE, 8'hFF);
                end
                3: begin
                    calm = 1'b1;
                    write_reg(ffpx_pkg::REG_HEADER_FIRST, 8'($urandom_range(0, 255)));
                    write_reg(ffpx_pkg::REG_HEADER_SECOND, 8'($urandom_range(0, 255)));
                    write_reg(ffpx_pkg::REG_FOOTER_VALUE, 8'($urandom_range(0, 255)));
                end
                default: ;
            endcase
            start = bytes_fed;
            while (bytes_fed - start < PHASE_BYTES) begin
                foreach (body[i]) begin
                    case ($urandom_range(0, 5))
                        0:       body[i] = 8'h00;
                        1:       body[i] = 8'hFF;
                        default: body[i] = 8'($urandom_range(0, 255));
                    endcase
                end
                pick = $urandom_range(0, 11);
                if (pick < 6)       kind = FR_GOOD;
                else if (pick == 6) kind = FR_BAD_CHECK;
                else if (pick == 7) kind = FR_BAD_FOOTER;
                else if (pick == 8) kind = FR_BAD_HEADER;
                else if (pick == 9) kind = FR_CUT;
                else                kind = FR_NOISE;
                queue_frame(kind, body);
            end
            wait_drained();
        end

        repeat (5) @(posedge aclk);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("[fixed_frame_parser_xor_check] OK");
        end else begin
            $display("[fixed_frame_parser_xor_check] ERROR");
        end
        $finish;
    end

endmodule
